@@ src/nlpd_pkg.sv @@
// Shared types and constants for the nested length-prefixed list decoder.
// Used by nlpd_ctrl, nlpd_datapath and the top level; depends on nothing.
package nlpd_pkg;

  // Parse phase of the stream.
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LEN  = 2'd1,
    PH_ITEM = 2'd2
  } phase_t;

  // Result record kinds.
  localparam logic KIND_OFFSET = 1'b0;
  localparam logic KIND_ITEM   = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_NEST_DEPTH = 2'd0;
  localparam logic [1:0] CFG_ITEM_BYTES = 2'd1;

  // Position of the final byte of a 32-bit big-endian count.
  localparam logic [2:0] LEN_LAST_BYTE = 3'd3;

  // Reset values of the configuration registers.
  localparam logic [3:0] NEST_DEPTH_RST = 4'd1;
  localparam logic [3:0] ITEM_BYTES_RST = 4'd4;
  localparam logic [3:0] ITEM_BYTES_MAX = 4'd8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // take the input item this cycle
    logic casc_step;  // run one step of the list-close cascade
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;   // output register can take a record this cycle
    logic need_casc;  // the item being accepted finishes a child list or item
    logic casc_end;   // the current cascade step is the final one
  } dp_sts_t;

endpackage

@@ src/nlpd_ctrl.sv @@
// Controller of the nested list decoder: switches between taking items
// and walking the close cascade. Depends on nlpd_pkg.
module nlpd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  nlpd_pkg::dp_sts_t   sts,
  output nlpd_pkg::ctl_cmd_t  cmd
);

  typedef enum logic {
    ST_IN   = 1'b0,
    ST_CASC = 1'b1
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    in_ready      = (state_r == ST_IN) && sts.out_free;
    cmd.accept    = in_valid && in_ready;
    cmd.casc_step = (state_r == ST_CASC) && sts.out_free;
    state_nxt     = state_r;
    case (state_r)
      ST_IN: begin
        if (cmd.accept && sts.need_casc) state_nxt = ST_CASC;
      end
      ST_CASC: begin
        if (cmd.casc_step && sts.casc_end) state_nxt = ST_IN;
      end
      default: state_nxt = ST_IN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IN;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ src/nlpd_datapath.sv @@
// Datapath of the nested list decoder: count stack, offsets, parse state,
// configuration registers and the output record register. Depends on nlpd_pkg.
module nlpd_datapath #(
  parameter int MAX_DEPTH    = 8,
  parameter int OFFSET_WIDTH = 48
) (
  input  logic                clk,
  input  logic                rst_n,
  input  nlpd_pkg::ctl_cmd_t  cmd,
  output nlpd_pkg::dp_sts_t   sts,
  input  logic [7:0]          in_data_byte,
  input  logic                in_entry_start,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [3:0]          cfg_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_kind,
  output logic [2:0]          out_level,
  output logic [47:0]         out_offset_value,
  output logic [7:0]          out_item_byte,
  output logic [2:0]          out_item_byte_index,
  output logic                out_entry_done,
  output logic                out_last
);

  localparam int AW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int LVW = $clog2(MAX_DEPTH + 1);
  localparam int OW  = OFFSET_WIDTH;
  localparam logic [4:0]     MAXD5     = 5'(MAX_DEPTH);
  localparam logic [LVW-1:0] MAXD_LV   = LVW'(MAX_DEPTH);
  localparam logic [LVW-1:0] LV_ONE    = LVW'(1);

  function automatic logic [2:0] lvl3(input logic [AW-1:0] idx);
    logic [AW+2:0] ext;
    ext = {3'b000, idx};
    return ext[2:0];
  endfunction

  function automatic logic [47:0] off48(input logic [OW-1:0] val);
    logic [OW+47:0] ext;
    ext = {48'd0, val};
    return ext[47:0];
  endfunction

  // Configuration and per-entry copies.
  logic [3:0]          nest_depth_r;
  logic [3:0]          item_bytes_r;
  logic [LVW-1:0]      run_depth_r, run_depth_nxt;
  logic [3:0]          run_item_r, run_item_nxt;

  // Parse state.
  nlpd_pkg::phase_t    phase_r, phase_nxt;
  logic [LVW-1:0]      level_r, level_nxt;
  logic [2:0]          bc_r, bc_nxt;
  logic [23:0]         shift_r, shift_nxt;
  logic [AW-1:0]       casc_p_r, casc_p_nxt;

  // Per-level stores.
  logic [31:0]         rem_r [MAX_DEPTH];
  logic [31:0]         len_r [MAX_DEPTH];
  logic [OW-1:0]       off_r [MAX_DEPTH];
  logic [MAX_DEPTH-1:0] one_r;  // remaining count of that level equals one

  // Output register.
  logic                out_valid_r;
  logic                kind_r, done_r, last_r;
  logic [2:0]          lvl_r, idx_r;
  logic [47:0]         offv_r;
  logic [7:0]          byte_r;

  // Effective values for the accepted item after an entry start.
  nlpd_pkg::phase_t    eff_phase;
  logic [LVW-1:0]      eff_level, eff_depth, child_lv, child_p;
  logic [2:0]          eff_bc;
  logic [23:0]         eff_shift;
  logic [3:0]          eff_item, bc_inc;
  logic [AW-1:0]       lv_idx, lvm1, dm1, pm1, off_idx;
  logic [31:0]         len_full, rem_dec;
  logic [OW-1:0]       off_rd, off_sum;
  logic                item_done, lw_we, cw_we, ow_we;

  // Record being loaded into the output register.
  logic                rec_load, rec_kind, rec_done, rec_last;
  logic [2:0]          rec_level, rec_idx;
  logic [47:0]         rec_off;
  logic [7:0]          rec_byte;

  logic [LVW-1:0]      depth_clamped;
  logic [3:0]          item_clamped;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (nest_depth_r == 4'd0) begin
      depth_clamped = LV_ONE;
    end else if ({1'b0, nest_depth_r} > MAXD5) begin
      depth_clamped = MAXD_LV;
    end else begin
      depth_clamped = LVW'(nest_depth_r);
    end
    if (item_bytes_r == 4'd0) begin
      item_clamped = 4'd1;
    end else if (item_bytes_r > nlpd_pkg::ITEM_BYTES_MAX) begin
      item_clamped = nlpd_pkg::ITEM_BYTES_MAX;
    end else begin
      item_clamped = item_bytes_r;
    end
  end

  always_comb begin
    eff_phase = in_entry_start ? nlpd_pkg::PH_LEN : phase_r;
    eff_level = in_entry_start ? '0 : level_r;
    eff_bc    = in_entry_start ? 3'd0 : bc_r;
    eff_shift = in_entry_start ? 24'd0 : shift_r;
    eff_depth = in_entry_start ? depth_clamped : run_depth_r;
    eff_item  = in_entry_start ? item_clamped : run_item_r;
    lv_idx    = eff_level[AW-1:0];
    lvm1      = lv_idx - AW'(1);
    child_lv  = eff_level + LV_ONE;
    dm1       = AW'(eff_depth - LV_ONE);
    len_full  = {eff_shift, in_data_byte};
    bc_inc    = {1'b0, eff_bc} + 4'd1;
    item_done = (bc_inc >= eff_item);
    pm1       = casc_p_r - AW'(1);
    child_p   = LVW'(casc_p_r) + LV_ONE;
    rem_dec   = rem_r[casc_p_r] - 32'd1;
    off_idx   = cmd.casc_step ? casc_p_r : lv_idx;
    off_rd    = off_r[off_idx];
    off_sum   = off_rd + OW'(len_r[casc_p_r]);
  end

  // A close at a level is the step's final record unless the parent list
  // closes right after it, which happens when the parent has one child left.
  always_comb begin
    sts.out_free  = !out_valid_r || out_ready;
    phase_nxt     = phase_r;
    level_nxt     = level_r;
    bc_nxt        = bc_r;
    shift_nxt     = shift_r;
    run_depth_nxt = run_depth_r;
    run_item_nxt  = run_item_r;
    casc_p_nxt    = casc_p_r;
    lw_we         = 1'b0;
    cw_we         = 1'b0;
    ow_we         = 1'b0;
    rec_load      = 1'b0;
    rec_kind      = nlpd_pkg::KIND_OFFSET;
    rec_level     = 3'd0;
    rec_off       = 48'd0;
    rec_byte      = 8'd0;
    rec_idx       = 3'd0;
    rec_done      = 1'b0;
    rec_last      = 1'b0;
    sts.need_casc = 1'b0;
    sts.casc_end  = 1'b0;
    if (cmd.accept) begin
      if (in_entry_start) begin
        run_depth_nxt = eff_depth;
        run_item_nxt  = eff_item;
        phase_nxt     = nlpd_pkg::PH_LEN;
        level_nxt     = '0;
        bc_nxt        = 3'd0;
        shift_nxt     = 24'd0;
      end
      case (eff_phase)
        nlpd_pkg::PH_LEN: begin
          if (eff_bc != nlpd_pkg::LEN_LAST_BYTE) begin
            shift_nxt = {eff_shift[15:0], in_data_byte};
            bc_nxt    = eff_bc + 3'd1;
          end else begin
            bc_nxt    = 3'd0;
            shift_nxt = 24'd0;
            lw_we     = 1'b1;
            if (len_full != 32'd0) begin
              level_nxt = child_lv;
              phase_nxt = (child_lv >= eff_depth) ? nlpd_pkg::PH_ITEM : nlpd_pkg::PH_LEN;
            end else begin
              // Empty list: its offset does not move.
              rec_load  = 1'b1;
              rec_kind  = nlpd_pkg::KIND_OFFSET;
              rec_level = lvl3(lv_idx);
              rec_off   = off48(off_rd);
              rec_done  = (eff_level == '0);
              rec_last  = (eff_level == '0) || !one_r[lvm1];
              if (eff_level == '0) begin
                phase_nxt = nlpd_pkg::PH_IDLE;
                level_nxt = '0;
              end else begin
                sts.need_casc = 1'b1;
                casc_p_nxt    = lvm1;
              end
            end
          end
        end
        nlpd_pkg::PH_ITEM: begin
          rec_load = 1'b1;
          rec_kind = nlpd_pkg::KIND_ITEM;
          rec_byte = in_data_byte;
          rec_idx  = eff_bc;
          if (item_done) begin
            bc_nxt        = 3'd0;
            sts.need_casc = 1'b1;
            casc_p_nxt    = dm1;
            rec_last      = !one_r[dm1];
          end else begin
            bc_nxt   = eff_bc + 3'd1;
            rec_last = 1'b1;
          end
        end
        default: ;
      endcase
    end else if (cmd.casc_step) begin
      cw_we = 1'b1;
      if (rem_dec != 32'd0) begin
        level_nxt    = child_p;
        phase_nxt    = (child_p >= run_depth_r) ? nlpd_pkg::PH_ITEM : nlpd_pkg::PH_LEN;
        bc_nxt       = 3'd0;
        shift_nxt    = 24'd0;
        sts.casc_end = 1'b1;
      end else begin
        ow_we     = 1'b1;
        rec_load  = 1'b1;
        rec_kind  = nlpd_pkg::KIND_OFFSET;
        rec_level = lvl3(casc_p_r);
        rec_off   = off48(off_sum);
        rec_done  = (casc_p_r == '0);
        rec_last  = (casc_p_r == '0) || !one_r[pm1];
        if (casc_p_r == '0) begin
          phase_nxt    = nlpd_pkg::PH_IDLE;
          level_nxt    = '0;
          bc_nxt       = 3'd0;
          shift_nxt    = 24'd0;
          sts.casc_end = 1'b1;
        end else begin
          casc_p_nxt = pm1;
        end
      end
    end
  end

  // Control state, configuration and offsets; reset clears state and offsets and loads the defaults.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nest_depth_r <= nlpd_pkg::NEST_DEPTH_RST;
      item_bytes_r <= nlpd_pkg::ITEM_BYTES_RST;
      run_depth_r  <= LV_ONE;
      run_item_r   <= nlpd_pkg::ITEM_BYTES_RST;
      phase_r      <= nlpd_pkg::PH_IDLE;
      level_r      <= '0;
      bc_r         <= 3'd0;
      shift_r      <= 24'd0;
      casc_p_r     <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < MAX_DEPTH; i++) begin
        off_r[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          nlpd_pkg::CFG_NEST_DEPTH: nest_depth_r <= cfg_data;
          nlpd_pkg::CFG_ITEM_BYTES: item_bytes_r <= cfg_data;
          default: ;
        endcase
      end
      run_depth_r <= run_depth_nxt;
      run_item_r  <= run_item_nxt;
      phase_r     <= phase_nxt;
      level_r     <= level_nxt;
      bc_r        <= bc_nxt;
      shift_r     <= shift_nxt;
      casc_p_r    <= casc_p_nxt;
      if (ow_we) off_r[casc_p_r] <= off_sum;
      if (rec_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Count stack and output payload; every entry is written before it is read.
  always_ff @(posedge clk) begin
    if (lw_we) begin
      len_r[lv_idx] <= len_full;
      rem_r[lv_idx] <= len_full;
      one_r[lv_idx] <= (len_full == 32'd1);
    end
    if (cw_we) begin
      rem_r[casc_p_r] <= rem_dec;
      one_r[casc_p_r] <= (rem_dec == 32'd1);
    end
    if (rec_load) begin
      kind_r <= rec_kind;
      lvl_r  <= rec_level;
      offv_r <= rec_off;
      byte_r <= rec_byte;
      idx_r  <= rec_idx;
      done_r <= rec_done;
      last_r <= rec_last;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_kind            = kind_r;
  assign out_level           = lvl_r;
  assign out_offset_value    = offv_r;
  assign out_item_byte       = byte_r;
  assign out_item_byte_index = idx_r;
  assign out_entry_done      = done_r;
  assign out_last            = last_r;

endmodule

@@ src/nested_length_prefixed_list_decoder_top.sv @@
// Top level of the nested length-prefixed list decoder; uses nlpd_ctrl, nlpd_datapath, nlpd_pkg.
// A record is registered and appears on the output in the cycle after its input item is accepted.
// Throughput: one item per cycle while the output is free; an item that ends an item or an empty
// inner list stops input while the close cascade walks up the levels (up to MAX_DEPTH), each step
// closing a list with a close record or, as the final step, counting down a parent list with children left.
// Reset clears parse state and offsets and loads depth 1, item size 4.
module nested_length_prefixed_list_decoder_top #(
  parameter int MAX_DEPTH    = 8,
  parameter int OFFSET_WIDTH = 48
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_entry_start,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [2:0]  out_level,
  output logic [47:0] out_offset_value,
  output logic [7:0]  out_item_byte,
  output logic [2:0]  out_item_byte_index,
  output logic        out_entry_done,
  output logic        out_last
);

  nlpd_pkg::ctl_cmd_t cmd;
  nlpd_pkg::dp_sts_t  sts;

  nlpd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  nlpd_datapath #(
    .MAX_DEPTH    (MAX_DEPTH),
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_data_byte        (in_data_byte),
    .in_entry_start      (in_entry_start),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_kind            (out_kind),
    .out_level           (out_level),
    .out_offset_value    (out_offset_value),
    .out_item_byte       (out_item_byte),
    .out_item_byte_index (out_item_byte_index),
    .out_entry_done      (out_entry_done),
    .out_last            (out_last)
  );

endmodule

@@ tb/tb_nested_length_prefixed_list_decoder_top.sv @@
// Self-checking testbench for nested_length_prefixed_list_decoder_top: directed and random
// byte streams of nested length-prefixed entries, checked against a built-in predictor.
// Depends on nlpd_pkg and the decoder RTL only.
module tb_nested_length_prefixed_list_decoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DEPTH = 8;
  localparam int SETTLE_CYCLES = MAX_DEPTH + 4;
  localparam int LONG_HOLD = 120;
  localparam int RUN_LIMIT_NS = 2_000_000;
  localparam int PHASES = 4;

  // Indexes that map to no register; writes there must change nothing.
  localparam logic [1:0] CFG_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } stream_byte_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  level;
    logic [47:0] offset;
    logic [7:0]  data;
    logic [2:0]  idx;
    logic        done;
    logic        last;
  } record_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_entry_start = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = nlpd_pkg::CFG_NEST_DEPTH;
  logic [3:0]  cfg_data = 4'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_kind;
  logic [2:0]  out_level;
  logic [47:0] out_offset_value;
  logic [7:0]  out_item_byte;
  logic [2:0]  out_item_byte_index;
  logic        out_entry_done;
  logic        out_last;

  nested_length_prefixed_list_decoder_top DUT (.*);

  always #2 clk = ~clk;

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Stream bytes waiting for the driver, and records the decoder still owes us.
  stream_byte_t pending[$];
  stream_byte_t entry_bytes[$];
  record_t      expected_records[$];
  int           errors = 0;

  // Predictor state.
  logic [31:0] remaining_counts [MAX_DEPTH];
  logic [47:0] level_offsets [MAX_DEPTH];
  logic [31:0] list_lengths [MAX_DEPTH];
  int unsigned cur_level = 0;
  nlpd_pkg::phase_t parse_ph = nlpd_pkg::PH_IDLE;
  logic [23:0] length_shift = 24'd0;
  int unsigned byte_pos = 0;
  logic [3:0]  depth_reg = nlpd_pkg::NEST_DEPTH_RST;
  logic [3:0]  isize_reg = nlpd_pkg::ITEM_BYTES_RST;
  int unsigned run_depth = 1;
  int unsigned run_isize = 4;
  int unsigned step_records = 0;

  initial begin
    for (int i = 0; i < MAX_DEPTH; i++) begin
      remaining_counts[i] = 32'd0;
      level_offsets[i] = 48'd0;
      list_lengths[i] = 32'd0;
    end
  end

  function automatic int unsigned eff_depth();
    if (depth_reg < 1) return 1;
    if (depth_reg > MAX_DEPTH) return MAX_DEPTH;
    return depth_reg;
  endfunction

  function automatic int unsigned eff_isize();
    if (isize_reg < 1) return 1;
    if (isize_reg > nlpd_pkg::ITEM_BYTES_MAX) return nlpd_pkg::ITEM_BYTES_MAX;
    return isize_reg;
  endfunction

  function automatic void note_record(logic kind, int unsigned lv, logic [47:0] off,
                                      logic [7:0] data, int unsigned idx, logic done);
    record_t r;
    r.kind = kind;
    r.level = lv[2:0];
    r.offset = off;
    r.data = data;
    r.idx = idx[2:0];
    r.done = done;
    r.last = 1'b0;
    expected_records.insert(expected_records.size(), r);
    step_records++;
  endfunction

  function automatic void open_child(int unsigned lv);
    byte_pos = 0;
    length_shift = 24'd0;
    cur_level = lv;
    parse_ph = (lv >= run_depth) ? nlpd_pkg::PH_ITEM : nlpd_pkg::PH_LEN;
  endfunction

  function automatic void close_list(int unsigned lv);
    level_offsets[lv] = level_offsets[lv] + {16'd0, list_lengths[lv]};
    note_record(nlpd_pkg::KIND_OFFSET, lv, level_offsets[lv], 8'd0, 0, lv == 0);
    if (lv == 0) begin
      parse_ph = nlpd_pkg::PH_IDLE;
      cur_level = 0;
      byte_pos = 0;
      length_shift = 24'd0;
    end
  endfunction

  // A child of the list at level p is complete; closes cascade upward while counts run out.
  function automatic void finish_child(int unsigned p);
    bit stop;
    stop = 1'b0;
    while (!stop) begin
      remaining_counts[p] = remaining_counts[p] - 32'd1;
      if (remaining_counts[p] != 0) begin
        open_child(p + 1);
        stop = 1'b1;
      end else begin
        close_list(p);
        if (p == 0) stop = 1'b1;
        else p--;
      end
    end
  endfunction

  function automatic void decode_stream_byte(logic [7:0] b, logic start);
    int unsigned lv;
    logic [31:0] cnt;
    record_t r;
    step_records = 0;
    if (start) begin
      run_depth = eff_depth();
      run_isize = eff_isize();
      open_child(0);
    end
    if (parse_ph == nlpd_pkg::PH_LEN) begin
      lv = cur_level;
      if (byte_pos < nlpd_pkg::LEN_LAST_BYTE) begin
        length_shift = {length_shift[15:0], b};
        byte_pos++;
      end else begin
        cnt = {length_shift, b};
        byte_pos = 0;
        length_shift = 24'd0;
        list_lengths[lv] = cnt;
        remaining_counts[lv] = cnt;
        if (cnt != 0) begin
          open_child(lv + 1);
        end else begin
          close_list(lv);
          if (lv != 0) finish_child(lv - 1);
        end
      end
    end else if (parse_ph == nlpd_pkg::PH_ITEM) begin
      note_record(nlpd_pkg::KIND_ITEM, 0, 48'd0, b, byte_pos, 1'b0);
      byte_pos++;
      if (byte_pos >= run_isize) begin
        byte_pos = 0;
        finish_child(run_depth - 1);
      end
    end
    if (step_records != 0) begin
      r = expected_records.pop_back();
      r.last = 1'b1;
      expected_records.insert(expected_records.size(), r);
    end
  endfunction

  // Stimulus construction.
  function automatic void push_stream(logic [7:0] data, logic start);
    stream_byte_t sb;
    sb.data = data;
    sb.start = start;
    entry_bytes.insert(entry_bytes.size(), sb);
  endfunction

  function automatic void add_count(logic [31:0] cnt, logic first);
    push_stream(cnt[31:24], first);
    push_stream(cnt[23:16], 1'b0);
    push_stream(cnt[15:8], 1'b0);
    push_stream(cnt[7:0], 1'b0);
  endfunction

  function automatic int unsigned commit_entry();
    int unsigned n;
    n = entry_bytes.size();
    while (entry_bytes.size() != 0) pending.insert(pending.size(), entry_bytes.pop_front());
    return n;
  endfunction

  function automatic int unsigned pick_length(int unsigned d, bit room);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (!room || r == 0) return 0;
    if (d > 3) return (r < 9) ? 1 : 2;
    return $urandom_range(1, 3);
  endfunction

  // Builds one entry for the current settings: mostly well formed, sometimes cut short
  // by the next entry start, sometimes raw bytes with a random count, plus idle noise.
  function automatic int unsigned queue_entry();
    int unsigned d, s, lvl, n, cap, mode, keep;
    int unsigned left [MAX_DEPTH];
    bit finished;
    d = eff_depth();
    s = eff_isize();
    cap = 4 * d + 2 * s + 8;
    mode = $urandom_range(0, 9);
    if (mode == 1) begin
      n = $urandom_range(4, 10);
      for (int i = 0; i < n; i++) push_stream(8'($urandom_range(0, 255)), i == 0);
    end else begin
      lvl = 0;
      n = pick_length(d, 1'b1);
      add_count(n, 1'b1);
      left[0] = n;
      finished = 1'b0;
      while (!finished) begin
        if (left[lvl] == 0) begin
          if (lvl == 0) finished = 1'b1;
          else lvl--;
        end else begin
          left[lvl]--;
          if (lvl + 1 >= d) begin
            for (int i = 0; i < s; i++) push_stream(8'($urandom_range(0, 255)), 1'b0);
          end else begin
            lvl++;
            n = pick_length(d, entry_bytes.size() < cap);
            add_count(n, 1'b0);
            left[lvl] = n;
          end
        end
      end
      if (mode == 0 && entry_bytes.size() > 1) begin
        keep = $urandom_range(1, entry_bytes.size() - 1);
        while (entry_bytes.size() > keep) void'(entry_bytes.pop_back());
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) push_stream(8'($urandom_range(0, 255)), 1'b0);
    end
    return commit_entry();
  endfunction

  // Driver: bursts of random length separated by random gaps.
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk) begin : driver
    stream_byte_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) decode_stream_byte(in_data_byte, in_entry_start);
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending.size() != 0) begin
          nxt = pending.pop_front();
          in_valid <= 1'b1;
          in_data_byte <= nxt.data;
          in_entry_start <= nxt.start;
          if (burst_left <= 1) begin
            if ($urandom_range(0, 4) == 0) begin
              burst_left <= $urandom_range(32, 64);
              gap_left <= 0;
            end else begin
              burst_left <= $urandom_range(1, 10);
              gap_left <= $urandom_range(0, 5);
            end
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: a rotating stall pattern, now and then a long hold-off so the block backs up.
  // The hold-off waits until the sender has plenty of items queued.
  logic [15:0] stall_bits = 16'hFFFF;
  logic [5:0]  pattern_age = 6'd0;
  int unsigned taken = 0;
  int unsigned next_hold = 10;
  int unsigned hold_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) taken <= taken + 1;
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (taken >= next_hold && pending.size() > 8) begin
        hold_left <= LONG_HOLD;
        next_hold <= next_hold + 400;
        out_ready <= 1'b0;
      end else begin
        out_ready <= stall_bits[0];
        if (pattern_age == 6'd63)
          stall_bits <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h0001);
        else
          stall_bits <= {stall_bits[0], stall_bits[15:1]};
        pattern_age <= pattern_age + 6'd1;
      end
    end
  end

  function automatic void check_field(string name, logic [47:0] got, logic [47:0] want);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    record_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_records.size() == 0) begin
        $display("%0t: unexpected record, expected none, actual kind %0d level %0d offset %0h",
                 $time, out_kind, out_level, out_offset_value);
        errors++;
      end else begin
        want = expected_records.pop_front();
        check_field("kind", out_kind, want.kind);
        check_field("level", out_level, want.level);
        check_field("offset_value", out_offset_value, want.offset);
        check_field("item_byte", out_item_byte, want.data);
        check_field("item_byte_index", out_item_byte_index, want.idx);
        check_field("entry_done", out_entry_done, want.done);
        check_field("last", out_last, want.last);
      end
    end
  end

  // Called at a rising edge; leaves cfg_valid high so back-to-back writes stay clean.
  task automatic write_reg(logic [1:0] idx, logic [3:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == nlpd_pkg::CFG_NEST_DEPTH) depth_reg = val;
    else if (idx == nlpd_pkg::CFG_ITEM_BYTES) isize_reg = val;
  endtask

  task automatic drain();
    while (pending.size() != 0 || in_valid || expected_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  logic [3:0] depth_plan [PHASES] = '{4'd0, 4'd15, 4'd3, 4'd1};
  logic [3:0] size_plan [PHASES] = '{4'd0, 4'd12, 4'd2, 4'd8};

  initial begin
    int unsigned added;
    @(posedge clk);
    while (!rst_n) @(posedge clk);

    // Reset settings: one-level lists of four-byte items.
    add_count(32'd0, 1'b1);
    push_stream(8'hA5, 1'b0);
    add_count(32'd1, 1'b1);
    push_stream(8'hFF, 1'b0);
    push_stream(8'h00, 1'b0);
    push_stream(8'h80, 1'b0);
    push_stream(8'h7F, 1'b0);
    // An entry abandoned partway through its count by a fresh entry start.
    push_stream(8'h00, 1'b1);
    push_stream(8'h00, 1'b0);
    add_count(32'd0, 1'b1);
    void'(commit_entry());
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      write_reg(nlpd_pkg::CFG_NEST_DEPTH, depth_plan[ph]);
      write_reg(nlpd_pkg::CFG_ITEM_BYTES, size_plan[ph]);
      if (ph == 2) begin
        write_reg(CFG_SPARE_A, 4'($urandom_range(0, 15)));
        write_reg(CFG_SPARE_B, 4'($urandom_range(0, 15)));
      end
      cfg_valid <= 1'b0;
      added = 0;
      while (added < 8) added += queue_entry();
      drain();
    end

    if (errors == 0) begin
      $display("[nested_length_prefixed_list_decoder_top] OK");
    end else begin
      $display("[nested_length_prefixed_list_decoder_top] ERROR");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("[nested_length_prefixed_list_decoder_top] ERROR");
    $finish;
  end

endmodule

@@ nested_length_prefixed_list_decoder_top.f @@
src/nlpd_pkg.sv
src/nlpd_ctrl.sv
src/nlpd_datapath.sv
src/nested_length_prefixed_list_decoder_top.sv
tb/tb_nested_length_prefixed_list_decoder_top.sv
